FILE: design/vectored_thrust_to_pulse_widths_top_assert.svh
// Assertion macros for the RTL of the block; only vttpw_ctrl includes them.
`ifndef VECTORED_THRUST_TO_PULSE_WIDTHS_TOP_ASSERT_SVH
`define VECTORED_THRUST_TO_PULSE_WIDTHS_TOP_ASSERT_SVH

// Condition on one edge implies a consequence on the next edge.
`define VTT_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("vttpw: sequencing check failed");

// Condition implies a consequence on the same edge.
`define VTT_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("vttpw: consistency check failed");

`endif

FILE: design/vttpw_pkg.sv
`default_nettype none
package vttpw_pkg;

    localparam int DEFAULT_ROTOR_COUNT = 4;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS = 16;

    localparam logic [30:0] PI_Q29 = 31'd1686629713;
    localparam logic signed [17:0] PI_Q12 = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
    localparam logic signed [17:0] MAX_TILT_Q12 = 18'sd16085;
    localparam logic signed [28:0] SERVO_GAIN_Q20 = 29'sd219078984;
    localparam logic signed [47:0] SERVO_CENTER_Q32 = 48'sd1500 <<< 32;

    localparam logic [11:0] RST_SERVO_MIN = 12'd500;
    localparam logic [11:0] RST_SERVO_MAX = 12'd2500;
    localparam logic [11:0] RST_MOTOR_MIN = 12'd1000;
    localparam logic [11:0] RST_MOTOR_MAX = 12'd1700;
    localparam logic [14:0] RST_MIN_FORCE = 15'd256;
    localparam logic [31:0] RST_QUAD_GAIN = 32'hFFFF_E43E;
    localparam logic [31:0] RST_LIN_GAIN = 32'd841836;
    localparam logic [12:0] RST_CURVE_OFFSET = 13'd1195;

    typedef enum logic [2:0] {
        REG_SERVO_MIN    = 3'd0,
        REG_SERVO_MAX    = 3'd1,
        REG_MOTOR_MIN    = 3'd2,
        REG_MOTOR_MAX    = 3'd3,
        REG_MIN_FORCE    = 3'd4,
        REG_QUAD_GAIN    = 3'd5,
        REG_LIN_GAIN     = 3'd6,
        REG_CURVE_OFFSET = 3'd7
    } reg_index_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SQ_X, OP_SQ_Y, OP_SQRT, OP_CORDIC_INIT, OP_CORDIC,
        OP_SCALE_LO, OP_SCALE_HI, OP_UNWRAP, OP_SERVO_MUL, OP_MOTOR_Q,
        OP_MOTOR_L, OP_MOTOR_SUM, OP_FINISH
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQRT, ST_CORDIC_INIT, ST_CORDIC,
        ST_SCALE_LO, ST_SCALE_HI, ST_UNWRAP, ST_SERVO_MUL, ST_MOTOR_Q,
        ST_MOTOR_L, ST_MOTOR_SUM, ST_FINISH
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_full;
    } dp_status_t;

    // atan(2^-i) in binary angle units, 2^32 per turn.
    function automatic logic [29:0] atan_step(input logic [3:0] i);
        logic [29:0] v;
        unique case (i)
            4'd0:  v = 30'd536870912;
            4'd1:  v = 30'd316933406;
            4'd2:  v = 30'd167458907;
            4'd3:  v = 30'd85004756;
            4'd4:  v = 30'd42667331;
            4'd5:  v = 30'd21354465;
            4'd6:  v = 30'd10679838;
            4'd7:  v = 30'd5340245;
            4'd8:  v = 30'd2670163;
            4'd9:  v = 30'd1335087;
            4'd10: v = 30'd667544;
            4'd11: v = 30'd333772;
            4'd12: v = 30'd166886;
            4'd13: v = 30'd83443;
            4'd14: v = 30'd41722;
            4'd15: v = 30'd20861;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: design/vectored_thrust_to_pulse_widths_top.sv
// An accepted request runs to its result in the output register before the next is taken,
// since the 16-step square root and the 16-step CORDIC share one iterative datapath
// under a single sequencer; the finish step holds while the output register is full.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n, asynchronous, active low) restores register defaults and zeroes
// every stored rotor tilt at once; no clearing pass is needed.
`default_nettype none
module vectored_thrust_to_pulse_widths_top #(
    parameter int ROTOR_COUNT = vttpw_pkg::DEFAULT_ROTOR_COUNT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         rotor,
    input  wire logic signed [15:0] force_x,
    input  wire logic signed [15:0] force_y,
    input  wire logic               armed,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              rotor_out,
    output logic [11:0]             tilt_pulse,
    output logic [11:0]             motor_pulse
);
    import vttpw_pkg::*;

    // The sequencer steps the datapath through squaring, the root, the
    // angle iterations, scaling, unwrapping and the two pulse curves.
    dp_cmd_t    cmd;
    dp_status_t status;

    vttpw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the configuration, the rotor tilts and the
    // output register that decouples the result from the next request.
    vttpw_dp #(
        .ROTOR_COUNT (ROTOR_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .rotor       (rotor),
        .force_x     (force_x),
        .force_y     (force_y),
        .armed       (armed),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rotor_out   (rotor_out),
        .tilt_pulse  (tilt_pulse),
        .motor_pulse (motor_pulse)
    );

endmodule
`default_nettype wire

FILE: design/vttpw_ctrl.sv
`default_nettype none
module vttpw_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 out_ready,
    input  wire vttpw_pkg::dp_status_t status,
    output vttpw_pkg::dp_cmd_t        cmd
);
    import vttpw_pkg::*;
    `include "vectored_thrust_to_pulse_widths_top_assert.svh"

    state_t     state_reg, state_next;
    logic [3:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_SQ_X;
                end
            end
            ST_SQ_X:
            begin
                cmd.op     = OP_SQ_X;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                cmd.op     = OP_SQ_Y;
                step_next  = '0;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.op    = OP_SQRT;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(SQRT_STEPS - 1))
                begin
                    state_next = ST_CORDIC_INIT;
                end
            end
            ST_CORDIC_INIT:
            begin
                cmd.op     = OP_CORDIC_INIT;
                step_next  = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cmd.op    = OP_CORDIC;
                step_next = step_reg + 4'd1;
                if (step_reg == 4'(CORDIC_STEPS - 1))
                begin
                    state_next = ST_SCALE_LO;
                end
            end
            ST_SCALE_LO:
            begin
                cmd.op     = OP_SCALE_LO;
                state_next = ST_SCALE_HI;
            end
            ST_SCALE_HI:
            begin
                cmd.op     = OP_SCALE_HI;
                state_next = ST_UNWRAP;
            end
            ST_UNWRAP:
            begin
                cmd.op     = OP_UNWRAP;
                state_next = ST_SERVO_MUL;
            end
            ST_SERVO_MUL:
            begin
                cmd.op     = OP_SERVO_MUL;
                state_next = ST_MOTOR_Q;
            end
            ST_MOTOR_Q:
            begin
                cmd.op     = OP_MOTOR_Q;
                state_next = ST_MOTOR_L;
            end
            ST_MOTOR_L:
            begin
                cmd.op     = OP_MOTOR_L;
                state_next = ST_MOTOR_SUM;
            end
            ST_MOTOR_SUM:
            begin
                cmd.op     = OP_MOTOR_SUM;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_full || out_ready)
                begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `VTT_ASSERT_NEXT(a_start, (state_reg == ST_IDLE && in_valid), (state_reg == ST_SQ_X))
    `VTT_ASSERT_NEXT(a_cordic_end, (state_reg == ST_CORDIC && step_reg == 4'd15),
                     (state_reg == ST_SCALE_LO))
    `VTT_ASSERT_NEXT(a_finish, (state_reg == ST_FINISH && !status.out_full),
                     (state_reg == ST_IDLE && status.out_full))

endmodule
`default_nettype wire

FILE: design/vttpw_dp.sv
`default_nettype none
module vttpw_dp #(
    parameter int ROTOR_COUNT = vttpw_pkg::DEFAULT_ROTOR_COUNT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire vttpw_pkg::dp_cmd_t    cmd,
    output vttpw_pkg::dp_status_t      status,
    input  wire logic                  cfg_write,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic [1:0]            rotor,
    input  wire logic signed [15:0]    force_x,
    input  wire logic signed [15:0]    force_y,
    input  wire logic                  armed,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 rotor_out,
    output logic [11:0]                tilt_pulse,
    output logic [11:0]                motor_pulse
);
    import vttpw_pkg::*;

    localparam int IDX_W = (ROTOR_COUNT > 1) ? $clog2(ROTOR_COUNT) : 1;

    // Configuration registers.
    logic [11:0]        servo_min_reg, servo_max_reg, motor_min_reg, motor_max_reg;
    logic [14:0]        min_force_reg;
    logic signed [31:0] quad_gain_reg, lin_gain_reg;
    logic signed [12:0] curve_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_min_reg    <= RST_SERVO_MIN;
            servo_max_reg    <= RST_SERVO_MAX;
            motor_min_reg    <= RST_MOTOR_MIN;
            motor_max_reg    <= RST_MOTOR_MAX;
            min_force_reg    <= RST_MIN_FORCE;
            quad_gain_reg    <= RST_QUAD_GAIN;
            lin_gain_reg     <= RST_LIN_GAIN;
            curve_offset_reg <= RST_CURVE_OFFSET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SERVO_MIN:    servo_min_reg    <= cfg_data[11:0];
                REG_SERVO_MAX:    servo_max_reg    <= cfg_data[11:0];
                REG_MOTOR_MIN:    motor_min_reg    <= cfg_data[11:0];
                REG_MOTOR_MAX:    motor_max_reg    <= cfg_data[11:0];
                REG_MIN_FORCE:    min_force_reg    <= cfg_data[14:0];
                REG_QUAD_GAIN:    quad_gain_reg    <= cfg_data;
                REG_LIN_GAIN:     lin_gain_reg     <= cfg_data;
                REG_CURVE_OFFSET: curve_offset_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Working registers.
    logic [1:0]         rotor_reg;
    logic               armed_reg, zero_reg;
    logic signed [15:0] x_reg, y_reg;
    logic [31:0]        sq_reg, rem_reg, root_reg;
    logic signed [32:0] cx_reg, cy_reg;
    logic signed [33:0] acc_reg;
    logic [63:0]        prod_reg;
    logic signed [15:0] tilt_use_reg;
    logic               ge_min_reg;
    logic signed [47:0] servo_prod_reg;
    logic signed [63:0] mq_reg, ml_reg, macc_reg;
    logic signed [15:0] tilt_reg [ROTOR_COUNT];

    // Stored tilt lookup.
    logic [4:0]         rotor_ext;
    logic               rotor_ok;
    logic [IDX_W-1:0]   rotor_idx;
    logic signed [15:0] cur_tilt;

    assign rotor_ext = {3'b000, rotor_reg};
    assign rotor_ok  = rotor_ext < 5'(ROTOR_COUNT);
    assign rotor_idx = rotor_ext[IDX_W-1:0];
    assign cur_tilt  = rotor_ok ? tilt_reg[rotor_idx] : 16'sd0;

    // Square root step.
    logic [31:0] sqrt_bit, sqrt_trial;
    logic [15:0] force_mag;
    assign sqrt_bit   = 32'd1 << (5'd30 - {cmd.step, 1'b0});
    assign sqrt_trial = root_reg + sqrt_bit;
    assign force_mag  = root_reg[15:0];

    // CORDIC step.
    logic signed [32:0] dx, dy;
    logic signed [33:0] atan_ext;
    assign dx       = cy_reg >>> cmd.step;
    assign dy       = cx_reg >>> cmd.step;
    assign atan_ext = $signed({4'b0000, atan_step(cmd.step)});

    logic [32:0] acc_mag;
    assign acc_mag = acc_reg[33] ? 33'(-acc_reg) : acc_reg[32:0];

    // Angle rounding, unwrap and fold.
    logic [63:0]        prod_rnd;
    logic signed [17:0] ang, diff, unw, fold;
    always_comb
    begin
        prod_rnd = prod_reg + (64'd1 << 47);
        if (zero_reg)
        begin
            ang = '0;
        end
        else if (acc_reg[33])
        begin
            ang = -$signed({2'b00, prod_rnd[63:48]});
        end
        else
        begin
            ang = $signed({2'b00, prod_rnd[63:48]});
        end
        diff = ang - 18'(cur_tilt);
        unw  = ang;
        if (diff > PI_Q12 || diff < -PI_Q12)
        begin
            if (ang < 18'(cur_tilt))
            begin
                unw = ang + TWO_PI_Q12;
            end
            else
            begin
                unw = ang - TWO_PI_Q12;
            end
        end
        priority if (unw > MAX_TILT_Q12)
        begin
            fold = unw - TWO_PI_Q12;
        end
        else if (unw < -MAX_TILT_Q12)
        begin
            fold = unw + TWO_PI_Q12;
        end
        else
        begin
            fold = unw;
        end
    end

    logic ge_min;
    assign ge_min = {1'b0, force_mag} >= {2'b00, min_force_reg};

    // Output formation.
    logic signed [47:0] servo_sum;
    logic [15:0]        servo_raw, servo_hi, servo_cl;
    logic [63:0]        macc_neg;
    logic signed [32:0] motor_cmd, motor_hi, motor_cl;
    always_comb
    begin
        servo_sum = servo_prod_reg + SERVO_CENTER_Q32;
        servo_raw = servo_sum[47] ? 16'd0 : servo_sum[47:32];
        servo_hi  = (servo_raw > {4'h0, servo_max_reg}) ? {4'h0, servo_max_reg} : servo_raw;
        servo_cl  = (servo_hi < {4'h0, servo_min_reg}) ? {4'h0, servo_min_reg} : servo_hi;

        macc_neg = 64'(-macc_reg);
        if (!ge_min_reg)
        begin
            motor_cmd = '0;
        end
        else if (macc_reg[63])
        begin
            motor_cmd = -$signed({1'b0, macc_neg[63:32]});
        end
        else
        begin
            motor_cmd = $signed({1'b0, macc_reg[63:32]});
        end
        motor_hi = (motor_cmd > $signed({21'd0, motor_max_reg}))
                 ? $signed({21'd0, motor_max_reg}) : motor_cmd;
        motor_cl = (motor_hi < $signed({21'd0, motor_min_reg}))
                 ? $signed({21'd0, motor_min_reg}) : motor_hi;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                rotor_reg <= rotor;
                x_reg     <= force_x;
                y_reg     <= force_y;
                armed_reg <= armed;
                zero_reg  <= (force_x == 16'sd0) && (force_y == 16'sd0);
            end
            OP_SQ_X:
            begin
                sq_reg <= 32'(x_reg * x_reg);
            end
            OP_SQ_Y:
            begin
                sq_reg   <= sq_reg + 32'(y_reg * y_reg);
                rem_reg  <= sq_reg + 32'(y_reg * y_reg);
                root_reg <= '0;
            end
            OP_SQRT:
            begin
                if (rem_reg >= sqrt_trial)
                begin
                    rem_reg  <= rem_reg - sqrt_trial;
                    root_reg <= (root_reg >> 1) + sqrt_bit;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
            OP_CORDIC_INIT:
            begin
                ge_min_reg <= ge_min;
                if (x_reg[15])
                begin
                    cx_reg  <= -(33'(x_reg) <<< 14);
                    cy_reg  <= -(33'(y_reg) <<< 14);
                    acc_reg <= y_reg[15] ? -(34'sd1 <<< 31) : (34'sd1 <<< 31);
                end
                else
                begin
                    cx_reg  <= 33'(x_reg) <<< 14;
                    cy_reg  <= 33'(y_reg) <<< 14;
                    acc_reg <= '0;
                end
            end
            OP_CORDIC:
            begin
                if (!cy_reg[32])
                begin
                    cx_reg  <= cx_reg + dx;
                    cy_reg  <= cy_reg - dy;
                    acc_reg <= acc_reg + atan_ext;
                end
                else
                begin
                    cx_reg  <= cx_reg - dx;
                    cy_reg  <= cy_reg + dy;
                    acc_reg <= acc_reg - atan_ext;
                end
            end
            OP_SCALE_LO:
            begin
                prod_reg <= 64'(acc_mag[15:0] * PI_Q29);
            end
            OP_SCALE_HI:
            begin
                prod_reg <= prod_reg + (64'(acc_mag[32:16] * PI_Q29) << 16);
            end
            OP_UNWRAP:
            begin
                tilt_use_reg <= ge_min_reg ? fold[15:0] : cur_tilt;
            end
            OP_SERVO_MUL:
            begin
                servo_prod_reg <= 48'(tilt_use_reg * SERVO_GAIN_Q20);
            end
            OP_MOTOR_Q:
            begin
                mq_reg <= 64'(quad_gain_reg * $signed({1'b0, sq_reg}));
            end
            OP_MOTOR_L:
            begin
                ml_reg <= 64'(lin_gain_reg * $signed({1'b0, force_mag}));
            end
            OP_MOTOR_SUM:
            begin
                macc_reg <= mq_reg + (ml_reg <<< 8) + (64'(curve_offset_reg) <<< 32);
            end
            default: ;
        endcase
    end

    // Per-rotor tilt store, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROTOR_COUNT; i++)
            begin
                tilt_reg[i] <= '0;
            end
        end
        else if (cmd.op == OP_UNWRAP && ge_min_reg && rotor_ok)
        begin
            tilt_reg[rotor_idx] <= fold[15:0];
        end
    end

    // Output register.
    logic out_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == OP_FINISH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FINISH)
        begin
            rotor_out   <= rotor_reg;
            tilt_pulse  <= servo_cl[11:0];
            motor_pulse <= armed_reg ? motor_cl[11:0] : 12'd0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_full = out_valid_reg;

endmodule
`default_nettype wire
